// ----- sv/psla_pkg.sv -----
// Shared types and constants for the probe slot LRU allocator.
package psla_pkg;

    localparam logic       REQ_FRAME  = 1'b0;
    localparam logic       REQ_PROBE  = 1'b1;

    localparam logic [1:0] FB_NONE    = 2'd0;
    localparam logic [1:0] FB_GATHER  = 2'd1;
    localparam logic [1:0] FB_STOP    = 2'd2;

    localparam int         SLOT_W     = 3;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input item
        logic look;       // resolve from the parallel hit / empty search
        logic scan_start; // clear the victim search
        logic scan_step;  // examine one slot for eviction
        logic fin;        // resolve from the victim search
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic quick;      // item resolves without a victim search
        logic scan_last;  // scan is on the last slot
        logic out_busy;   // result register still occupied
    } t_stat;

endpackage

// ----- sv/psla_ctrl.sv -----
// Controller state machine of the probe slot LRU allocator.
module psla_ctrl import psla_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!i_stat.quick) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (!i_stat.out_busy) begin
                    o_cmd.look = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/psla_dp.sv -----
// Datapath of the probe slot LRU allocator: slot table, search and result register.
module psla_dp import psla_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_req_type,
    input  logic [31:0]       i_frame_stamp,
    input  logic [63:0]       i_probe_id,
    input  logic              i_has_render_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kept,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_update_now,
    output logic [1:0]        o_feedback,
    output logic              o_no_room
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [63:0]   r_probe [SLOTS];
    logic [31:0]   r_stamp [SLOTS];
    logic [31:0]   r_cur;
    logic          r_refresh;
    logic          r_defer;

    logic          r_type;
    logic [63:0]   r_id;
    logic          r_render;

    logic [IW-1:0] r_idx;
    logic          r_vic_have;
    logic [IW-1:0] r_vic_idx;
    logic [31:0]   r_vic_stamp;

    logic          hit_c, empty_c;
    logic [IW-1:0] hit_idx, empty_idx;
    logic [31:0]   lane_stamp;
    logic          lane_better;

    logic          do_res, hit, found;
    logic [IW-1:0] pick;
    logic [IW+SLOT_W-1:0] pick_ext;
    logic          res_kept, res_upd, res_nr;
    logic [1:0]    res_fb;
    logic          wr_en, set_refresh, set_defer, frame_load;

    // parallel associative match and first empty slot; lowest index wins
    always_comb begin
        hit_c     = 1'b0;
        empty_c   = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_probe[i] == r_id) begin
                hit_c   = 1'b1;
                hit_idx = IW'(i);
            end
            if (r_probe[i] == 64'd0) begin
                empty_c   = 1'b1;
                empty_idx = IW'(i);
            end
        end
    end

    assign lane_stamp  = r_stamp[r_idx];
    assign lane_better = (lane_stamp != r_cur) && (!r_vic_have || (lane_stamp < r_vic_stamp));

    assign o_stat.quick     = (r_type == REQ_FRAME) || (r_id == 64'd0) || hit_c || empty_c;
    assign o_stat.scan_last = (r_idx == IW'(SLOTS - 1));
    assign o_stat.out_busy  = o_out_valid && !i_out_ready;

    assign do_res = i_cmd.look || i_cmd.fin;

    always_comb begin
        if (i_cmd.look) begin
            hit   = hit_c;
            found = hit_c || empty_c;
            pick  = hit_c ? hit_idx : empty_idx;
        end else begin
            hit   = 1'b0;
            found = r_vic_have;
            pick  = r_vic_idx;
        end
    end

    assign pick_ext = {{SLOT_W{1'b0}}, pick};

    always_comb begin
        res_kept    = 1'b0;
        res_upd     = 1'b0;
        res_nr      = 1'b0;
        res_fb      = FB_NONE;
        wr_en       = 1'b0;
        set_refresh = 1'b0;
        set_defer   = 1'b0;
        frame_load  = 1'b0;
        if (!do_res) begin
            // no resolve this cycle
        end else if (i_cmd.look && (r_type == REQ_FRAME)) begin
            frame_load = 1'b1;
        end else if (i_cmd.look && (r_id == 64'd0)) begin
            // ignored request
        end else if (!found) begin
            res_nr = 1'b1;
        end else if (!hit && (r_refresh || !r_render)) begin
            res_fb    = r_defer ? FB_NONE : FB_GATHER;
            set_defer = 1'b1;
        end else begin
            res_kept    = 1'b1;
            res_upd     = !hit;
            res_fb      = r_render ? FB_STOP : FB_NONE;
            wr_en       = 1'b1;
            set_refresh = !hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_probe[i] <= '0;
                r_stamp[i] <= '0;
            end
            r_cur       <= '0;
            r_refresh   <= 1'b0;
            r_defer     <= 1'b0;
            r_idx       <= '0;
            r_vic_have  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (frame_load) begin
                // frame stamp travels in the victim stamp register
                r_cur     <= r_vic_stamp;
                r_refresh <= 1'b0;
                r_defer   <= 1'b0;
            end
            if (set_refresh) begin
                r_refresh <= 1'b1;
            end
            if (set_defer) begin
                r_defer <= 1'b1;
            end
            if (wr_en) begin
                r_probe[pick] <= r_id;
                r_stamp[pick] <= r_cur;
            end
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_vic_have <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (!o_stat.scan_last) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (lane_better) begin
                    r_vic_have <= 1'b1;
                end
            end
            if (do_res) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type      <= i_req_type;
            r_id        <= i_probe_id;
            r_render    <= i_has_render_data;
            r_vic_stamp <= i_frame_stamp;
        end else if (i_cmd.scan_step && lane_better) begin
            r_vic_stamp <= lane_stamp;
        end
        if (i_cmd.scan_step && lane_better) begin
            r_vic_idx <= r_idx;
        end
        if (do_res) begin
            o_kept       <= res_kept;
            o_slot       <= res_kept ? pick_ext[SLOT_W-1:0] : '0;
            o_update_now <= res_upd;
            o_feedback   <= res_fb;
            o_no_room    <= res_nr;
        end
    end

endmodule

// ----- sv/probe_slot_lru_allocator.sv -----
// Top level of the probe slot LRU allocator: controller plus datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: either a
//   frame start (req_type 0, loads frame_stamp and clears the per-frame
//   refresh and deferral flags) or a probe request (req_type 1).
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   item per input item, in order.
//   A frame start, a zero id, a hit or a miss that finds an empty slot
//   is captured, then resolved from the parallel associative search (a
//   kept slot is written into the slot table). A miss on a full table
//   walks the slots one per cycle to find the least recently used one not
//   touched this frame, then resolves from that walk. The walk over the
//   stamp table sets the long case.
//   One item is in work at a time; the next item is taken as soon as the
//   previous one has been written into the result register, even if that
//   result is still waiting at the output.
//   A stalled receiver only holds back the resolve step; the table is not
//   touched until the result register is free.
//   Reset (synchronous, active low) empties all slots, zeroes their stamps,
//   the current stamp and both per-frame flags, and drops o_out_valid.
module probe_slot_lru_allocator import psla_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [31:0]       i_frame_stamp,
    input  logic [63:0]       i_probe_id,
    input  logic              i_has_render_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kept,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_update_now,
    output logic [1:0]        o_feedback,
    output logic              o_no_room
);

    t_cmd  cmd;
    t_stat stat;

    psla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    psla_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_req_type        (i_req_type),
        .i_frame_stamp     (i_frame_stamp),
        .i_probe_id        (i_probe_id),
        .i_has_render_data (i_has_render_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kept            (o_kept),
        .o_slot            (o_slot),
        .o_update_now      (o_update_now),
        .o_feedback        (o_feedback),
        .o_no_room         (o_no_room)
    );

endmodule
